@@ hdl/mlcs_pkg.sv @@
// ----------------------------------------------------------------------------
// mlcs_pkg
// Shared types and constants for the motor lock command sequencer.
// ----------------------------------------------------------------------------
package mlcs_pkg;

   // request ring
   localparam int QUEUE_DEPTH = 16;
   localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);

   // hold timer
   localparam int TIMER_BITS = 16;
   localparam int HOLD_W     = 16;
   localparam int CMP_W      = (TIMER_BITS > HOLD_W) ? TIMER_BITS : HOLD_W;

   // reset values of the hold registers
   localparam logic [HOLD_W-1:0] OPEN_HOLD_RESET  = HOLD_W'(500);
   localparam logic [HOLD_W-1:0] CLOSE_HOLD_RESET = HOLD_W'(30);

   // configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OPEN_HOLD  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOSE_HOLD = 1'b1;

   // issue queue between front and back
   localparam int ISSUE_DEPTH = 2;
   localparam int ISSUE_PTR_W = (ISSUE_DEPTH > 1) ? $clog2(ISSUE_DEPTH) : 1;
   localparam int ISSUE_CNT_W = $clog2(ISSUE_DEPTH + 1);

   localparam int PHASE_W = 3;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_TICK    = 1'b1
   } op_type;

   typedef struct packed {
      op_type op;
      logic   target;
      logic   sensor;
   } item_type;

   typedef struct packed {
      logic [HOLD_W-1:0] open_hold;
      logic [HOLD_W-1:0] close_hold;
   } cfg_type;

endpackage

@@ hdl/mlcs_front.sv @@
// ----------------------------------------------------------------------------
// mlcs_front
// Input register stage: takes request transfers and decodes them into items.
// ----------------------------------------------------------------------------
module mlcs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_command,
   input  logic              req_target_state,
   input  logic              req_end_stop_level,
   output logic              push_valid,
   output mlcs_pkg::item_type push_item,
   input  logic              issue_full
);

   logic               hold_valid_ff;
   logic               hold_valid_in;
   mlcs_pkg::item_type hold_item_ff;
   logic               push;
   logic               load;

   assign push      = hold_valid_ff && !issue_full;
   assign req_stall = hold_valid_ff && issue_full;
   assign load      = req_valid && !req_stall;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (load) begin
         hold_valid_in = 1'b1;
      end else if (push) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   // payload: classify the command
   always_ff @(posedge clock) begin
      if (load) begin
         hold_item_ff.op     <= req_command ? mlcs_pkg::OP_TICK : mlcs_pkg::OP_ENQUEUE;
         hold_item_ff.target <= req_target_state;
         hold_item_ff.sensor <= req_end_stop_level;
      end
   end

   assign push_valid = push;
   assign push_item  = hold_item_ff;

endmodule

@@ hdl/mlcs_issue_fifo.sv @@
// ----------------------------------------------------------------------------
// mlcs_issue_fifo
// Short queue of decoded items between the front and the back.
// ----------------------------------------------------------------------------
module mlcs_issue_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mlcs_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output mlcs_pkg::item_type pop_item
);

   mlcs_pkg::item_type                  slot_ff [mlcs_pkg::ISSUE_DEPTH];
   logic [mlcs_pkg::ISSUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [mlcs_pkg::ISSUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [mlcs_pkg::ISSUE_CNT_W-1:0]    count_ff, count_in;

   function automatic logic [mlcs_pkg::ISSUE_PTR_W-1:0] ptr_next(
      input logic [mlcs_pkg::ISSUE_PTR_W-1:0] p);
      if (p == mlcs_pkg::ISSUE_PTR_W'(mlcs_pkg::ISSUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign full     = (count_ff == mlcs_pkg::ISSUE_CNT_W'(mlcs_pkg::ISSUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ hdl/mlcs_back.sv @@
// ----------------------------------------------------------------------------
// mlcs_back
// Executes items in order: request ring, hold timer, phase sequencer and the
// result register.
// ----------------------------------------------------------------------------
module mlcs_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           item_valid,
   input  mlcs_pkg::item_type             item,
   output logic                           pop,
   input  mlcs_pkg::cfg_type              cfg,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_request_refused,
   output logic                           rsp_motor_direction,
   output logic                           rsp_motor_enable,
   output logic                           rsp_latch_state,
   output logic [mlcs_pkg::PHASE_W-1:0]   rsp_sequencer_phase
);

   typedef enum logic [mlcs_pkg::PHASE_W-1:0] {
      PH_WAIT  = 3'd0,
      PH_READ  = 3'd1,
      PH_EXEC  = 3'd2,
      PH_AWAIT = 3'd3,
      PH_HOLD  = 3'd4
   } phase_type;

   localparam int IW = mlcs_pkg::QUEUE_IDX_W;
   localparam int TW = mlcs_pkg::TIMER_BITS;
   localparam int CW = mlcs_pkg::CMP_W;

   logic          store_ff [mlcs_pkg::QUEUE_DEPTH];
   logic          store_we;
   logic          store_rd;

   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic [IW-1:0] tail_next;
   phase_type     phase_ff, phase_in;
   logic          active_ff, active_in;
   logic          latch_ff, latch_in;
   logic [TW-1:0] timer_ff, timer_in;
   logic          dir_ff, dir_in;
   logic          en_ff, en_in;
   logic          refused;
   logic [mlcs_pkg::HOLD_W-1:0] hold;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_refused_ff;
   logic          rsp_dir_ff;
   logic          rsp_en_ff;
   logic          rsp_latch_ff;
   logic [mlcs_pkg::PHASE_W-1:0] rsp_phase_ff;

   function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i);
      if (i == IW'(mlcs_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return i + 1'b1;
   endfunction

   // take an item whenever the result register is free or being drained
   assign pop       = item_valid && (!rsp_valid_ff || !rsp_stall);
   assign tail_next = ring_next(tail_ff);
   assign store_rd  = store_ff[head_ff];
   assign hold      = (active_ff == 1'b0) ? cfg.open_hold : cfg.close_hold;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      phase_in  = phase_ff;
      active_in = active_ff;
      latch_in  = latch_ff;
      timer_in  = timer_ff;
      dir_in    = dir_ff;
      en_in     = en_ff;
      refused   = 1'b0;
      store_we  = 1'b0;
      if (pop) begin
         if (item.op == mlcs_pkg::OP_ENQUEUE) begin
            if (tail_next == head_ff) begin
               refused = 1'b1;
            end else begin
               store_we = 1'b1;
               tail_in  = tail_next;
            end
         end else begin
            // timer saturates before the sequencer looks at it
            if (timer_ff != '1) begin
               timer_in = timer_ff + 1'b1;
            end
            case (phase_ff)
               PH_WAIT: begin
                  phase_in = PH_READ;
               end
               PH_READ: begin
                  if (head_ff != tail_ff) begin
                     active_in = store_rd;
                     head_in   = ring_next(head_ff);
                     if (store_rd != latch_ff) begin
                        phase_in = PH_EXEC;
                     end
                  end
               end
               PH_EXEC: begin
                  dir_in   = !active_ff;
                  en_in    = 1'b1;
                  phase_in = PH_AWAIT;
               end
               PH_AWAIT: begin
                  if (item.sensor == active_ff) begin
                     timer_in = '0;
                     phase_in = PH_HOLD;
                  end
               end
               PH_HOLD: begin
                  if (CW'(timer_in) > CW'(hold)) begin
                     en_in    = 1'b0;
                     latch_in = active_ff;
                     phase_in = PH_WAIT;
                  end
               end
               default: begin
                  phase_in = PH_WAIT;
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         phase_ff     <= PH_WAIT;
         active_ff    <= 1'b0;
         latch_ff     <= 1'b0;
         timer_ff     <= '0;
         dir_ff       <= 1'b0;
         en_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         phase_ff     <= phase_in;
         active_ff    <= active_in;
         latch_ff     <= latch_in;
         timer_ff     <= timer_in;
         dir_ff       <= dir_in;
         en_ff        <= en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[tail_ff] <= item.target;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_refused_ff <= refused;
         rsp_dir_ff     <= dir_in;
         rsp_en_ff      <= en_in;
         rsp_latch_ff   <= latch_in;
         rsp_phase_ff   <= phase_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_request_refused = rsp_refused_ff;
   assign rsp_motor_direction = rsp_dir_ff;
   assign rsp_motor_enable    = rsp_en_ff;
   assign rsp_latch_state     = rsp_latch_ff;
   assign rsp_sequencer_phase = rsp_phase_ff;

endmodule

@@ hdl/motor_lock_command_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// motor_lock_command_sequencer_top
// Command sequencer for a motor-driven latch, with hold-time registers.
// ----------------------------------------------------------------------------
// Each req transfer is either an enqueue (command 0: target_state goes into a
// 16-slot ring that holds up to 15 requests, refused when full) or a tick
// (command 1: the hold timer advances, saturating, and the sequencer steps
// through wait, read, execute, await sensor and hold timing). Every req
// transfer yields exactly one rsp transfer carrying the refused flag of that
// enqueue (0 on a tick) and the motor drive, latch state and phase after the
// item. One item is taken per clock while rsp is not stalled. A result is
// offered on rsp once its item has passed the input register and the
// two-entry issue queue, in that order, and been loaded into the result
// register. While rsp is stalled the result register, the issue queue and
// the input register fill in turn, and req_stall rises once four items are
// held; it falls in the cycle after rsp_stall does. The hold registers take
// writes on the csr port at any time (csr_ready is tied high) but are only
// to be changed while the block is idle; index 0 is the opening hold time,
// index 1 the closing one.
// ----------------------------------------------------------------------------
module motor_lock_command_sequencer_top (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_command,
   input  logic                               req_target_state,
   input  logic                               req_end_stop_level,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_request_refused,
   output logic                               rsp_motor_direction,
   output logic                               rsp_motor_enable,
   output logic                               rsp_latch_state,
   output logic [mlcs_pkg::PHASE_W-1:0]       rsp_sequencer_phase,
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mlcs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mlcs_pkg::HOLD_W-1:0]        csr_wdata
);

   mlcs_pkg::cfg_type  cfg_ff;
   logic               push_valid;
   mlcs_pkg::item_type push_item;
   logic               issue_full;
   logic               issue_empty;
   logic               pop;
   mlcs_pkg::item_type pop_item;

   // hold-time registers; always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.open_hold  <= mlcs_pkg::OPEN_HOLD_RESET;
         cfg_ff.close_hold <= mlcs_pkg::CLOSE_HOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mlcs_pkg::CSR_OPEN_HOLD:  cfg_ff.open_hold  <= csr_wdata;
            mlcs_pkg::CSR_CLOSE_HOLD: cfg_ff.close_hold <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // front: input register and command decode
   mlcs_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_target_state   (req_target_state),
      .req_end_stop_level (req_end_stop_level),
      .push_valid         (push_valid),
      .push_item          (push_item),
      .issue_full         (issue_full)
   );

   // decouples the front from result back-pressure
   mlcs_issue_fifo u_issue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_item (push_item),
      .full      (issue_full),
      .pop       (pop),
      .empty     (issue_empty),
      .pop_item  (pop_item)
   );

   // back: ring, timer, sequencer, result register
   mlcs_back u_back (
      .clock               (clock),
      .reset               (reset),
      .item_valid          (!issue_empty),
      .item                (pop_item),
      .pop                 (pop),
      .cfg                 (cfg_ff),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_request_refused (rsp_request_refused),
      .rsp_motor_direction (rsp_motor_direction),
      .rsp_motor_enable    (rsp_motor_enable),
      .rsp_latch_state     (rsp_latch_state),
      .rsp_sequencer_phase (rsp_sequencer_phase)
   );

endmodule
